/* rtl/core/tdpt_pkg.sv */
// Shared constants, types and helper structs of the trial division prime table.
package tdpt_pkg;

   // Number of table slots and width of a tested number.
   localparam int PrimeSlots = 1024;
   localparam int NumberBits = 32;

   // Derived widths.
   localparam int SlotBits   = (PrimeSlots > 1) ? $clog2(PrimeSlots) : 1;
   localparam int CountBits  = $clog2(PrimeSlots + 1);
   localparam int BitCntBits = (NumberBits > 1) ? $clog2(NumberBits) : 1;

   // Width of the count field on the result channel.
   localparam int CountFieldBits = 11;

   typedef logic [NumberBits-1:0] number_type;
   typedef logic [CountBits-1:0]  count_type;
   typedef logic [SlotBits-1:0]   slot_type;

   // The table holds only this prime after reset.
   localparam number_type FirstPrime = NumberBits'(2);

   // One beat that travels down the chain: a single candidate bit, MSB first.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic dbit;
      logic hit;
   } beat_type;

   // Table write issued when a prime is appended.
   typedef struct packed {
      logic       en;
      slot_type   slot;
      number_type value;
   } write_type;

endpackage

/* rtl/core/tdpt_cell.sv */
// One cell of the chain: a stored prime and a bit-serial remainder against it.
module tdpt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tdpt_pkg::beat_type   up_beat,
   input  logic                 active,
   input  logic                 wr_en,
   input  tdpt_pkg::number_type wr_value,
   output tdpt_pkg::beat_type   down_beat
);
   import tdpt_pkg::*;

   number_type             prime_ff, prime_in;
   number_type             rem_ff, rem_in;
   beat_type               out_ff, out_in;
   number_type             first_rem;
   logic [NumberBits:0]    trial;
   logic [NumberBits:0]    wide_prime;
   number_type             remainder;
   logic                   divides;

   always_comb begin
      prime_in = wr_en ? wr_value : prime_ff;

      // Shift the next bit into the partial remainder and reduce once.
      first_rem  = up_beat.first ? '0 : rem_ff;
      trial      = {first_rem, up_beat.dbit};
      wide_prime = {1'b0, prime_ff};
      if (trial >= wide_prime) begin
         remainder = NumberBits'(trial - wide_prime);
      end else begin
         remainder = NumberBits'(trial);
      end
      rem_in = up_beat.valid ? remainder : rem_ff;

      // A zero entry never counts as a divisor.
      divides = up_beat.last && active && (prime_ff != '0) && (remainder == '0);

      out_in     = up_beat;
      out_in.hit = up_beat.hit | divides;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= FirstPrime;
         out_ff   <= '0;
      end else begin
         prime_ff <= prime_in;
         out_ff   <= out_in;
      end
      rem_ff <= rem_in;
   end

   assign down_beat = out_ff;

endmodule

/* rtl/core/tdpt_chain.sv */
// Row of prime cells with slot decoding for appends and occupancy.
module tdpt_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  tdpt_pkg::beat_type   feed_beat,
   input  tdpt_pkg::write_type  wr,
   input  tdpt_pkg::count_type  count,
   output tdpt_pkg::beat_type   tail_beat
);
   import tdpt_pkg::*;

   beat_type link [0:PrimeSlots];

   assign link[0] = feed_beat;

   for (genvar k = 0; k < PrimeSlots; k++) begin : g_cell
      logic active;
      logic wr_en;

      assign active = count > CountBits'(k);
      assign wr_en  = wr.en && (wr.slot == SlotBits'(k));

      tdpt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_beat   (link[k]),
         .active    (active),
         .wr_en     (wr_en),
         .wr_value  (wr.value),
         .down_beat (link[k+1])
      );
   end

   assign tail_beat = link[PrimeSlots];

endmodule

/* rtl/core/trial_division_prime_table.sv */
// Top level of the trial division prime table: feeder, chain and result register.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_candidate[31:0]
//   rsp_      out        rsp_valid/rsp_stall   rsp_is_prime, rsp_appended, rsp_table_full,
//                                              rsp_prime_count[10:0]
//
// Each candidate is sent down a chain of 1024 cells, one bit per cycle, MSB first. Every cell
// holds one table entry and reduces its own running remainder by one bit per beat, so the
// item passes through the feed register and every cell register before the next candidate
// can be taken.
// Reset is synchronous and active high; it leaves the table holding only 2 and the result
// register empty.
// A new candidate is taken once the result register accepts the last result, even while it
// stalls; a result that finishes behind a stalled one waits in a holding register.
module trial_division_prime_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_prime,
   output logic        rsp_appended,
   output logic        rsp_table_full,
   output logic [10:0] rsp_prime_count
);
   import tdpt_pkg::*;

   typedef enum logic [2:0] {
      StIdle = 3'b001,
      StRun  = 3'b010,
      StHold = 3'b100
   } state_type;

   typedef struct packed {
      logic                      is_prime;
      logic                      appended;
      logic                      table_full;
      logic [CountFieldBits-1:0] prime_count;
   } result_type;

   state_type               state_ff, state_in;
   number_type              cand_ff, cand_in;
   number_type              shift_ff, shift_in;
   logic [BitCntBits-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                    feeding_ff, feeding_in;
   beat_type                feed_ff, feed_in;
   count_type               count_ff, count_in;
   result_type              pend_ff, pend_in;
   result_type              rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   beat_type                tail_beat;
   write_type               wr;
   logic                    accept;
   logic                    done;
   logic                    prime;
   logic                    room;
   logic                    added;
   count_type               count_next;
   result_type              finished;
   logic                    rsp_free;

   // The chain carries one candidate at a time.
   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && !req_stall;

   tdpt_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .feed_beat (feed_ff),
      .wr        (wr),
      .count     (count_ff),
      .tail_beat (tail_beat)
   );

   always_comb begin
      // The last beat leaving the chain carries the verdict of every cell.
      done       = (state_ff == StRun) && tail_beat.valid && tail_beat.last;
      prime      = !tail_beat.hit;
      room       = count_ff < CountBits'(PrimeSlots);
      added      = done && prime && room;
      count_next = count_ff + CountBits'(added);

      finished.is_prime    = prime;
      finished.appended    = prime && room;
      finished.table_full  = prime && !room;
      finished.prime_count = CountFieldBits'(count_next);

      // A prime goes into the first free slot.
      wr.en    = added;
      wr.slot  = SlotBits'(count_ff);
      wr.value = cand_ff;
      count_in = count_next;

      // Feeder: one candidate bit per cycle, MSB first.
      cand_in    = cand_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      feeding_in = feeding_ff;
      feed_in    = '0;
      if (accept) begin
         cand_in    = NumberBits'(req_candidate);
         shift_in   = NumberBits'(req_candidate);
         bit_cnt_in = '0;
         feeding_in = 1'b1;
      end else if (feeding_ff) begin
         feed_in.valid = 1'b1;
         feed_in.first = (bit_cnt_ff == '0);
         feed_in.last  = (bit_cnt_ff == BitCntBits'(NumberBits - 1));
         feed_in.dbit  = shift_ff[NumberBits-1];
         shift_in      = shift_ff << 1;
         bit_cnt_in    = bit_cnt_ff + BitCntBits'(1);
         if (feed_in.last) begin
            feeding_in = 1'b0;
         end
      end

      // Result register: it frees up when empty or when its transfer completes.
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StRun;
            end
         end
         StRun: begin
            if (done) begin
               if (rsp_free) begin
                  rsp_in       = finished;
                  rsp_valid_in = 1'b1;
                  state_in     = StIdle;
               end else begin
                  pend_in  = finished;
                  state_in = StHold;
               end
            end
         end
         StHold: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         feeding_ff   <= 1'b0;
         feed_ff      <= '0;
         count_ff     <= CountBits'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         feeding_ff   <= feeding_in;
         feed_ff      <= feed_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff    <= cand_in;
      shift_ff   <= shift_in;
      bit_cnt_ff <= bit_cnt_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_prime    = rsp_ff.is_prime;
   assign rsp_appended    = rsp_ff.appended;
   assign rsp_table_full  = rsp_ff.table_full;
   assign rsp_prime_count = rsp_ff.prime_count;

   // The table never holds more primes than it has slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CountBits'(PrimeSlots)) && (count_ff != '0))
      else $error("prime count out of range");

   // Beats leave the chain only while an item is being worked on.
   a_tail_in_run: assert property (@(posedge clock) disable iff (reset)
      tail_beat.valid |-> (state_ff == StRun))
      else $error("chain produced a beat outside of a run");

   // A result is either appended or flagged full, and only when it is prime.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.appended && rsp_ff.table_full)
                       && (rsp_ff.is_prime || !(rsp_ff.appended || rsp_ff.table_full)))
      else $error("inconsistent result flags");

   // The count moves only when an item completes.
   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      !done |=> (count_ff == $past(count_ff)))
      else $error("prime count changed without a completed item");

endmodule

/* dv/trial_division_prime_table_checker.sv */
// Checker of the trial division prime table: predicts every result and compares it field by field.
`timescale 1ns / 1ps
module trial_division_prime_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_candidate,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_is_prime,
   input  logic        rsp_appended,
   input  logic        rsp_table_full,
   input  logic [10:0] rsp_prime_count,
   output int          error_count,
   output int          outstanding,
   output int          held_primes,
   output int          checked_count,
   output int          prime_results,
   output int          full_results
);
   import tdpt_pkg::*;

   typedef struct packed {
      number_type                candidate;
      logic                      is_prime;
      logic                      appended;
      logic                      table_full;
      logic [CountFieldBits-1:0] prime_count;
   } verdict_type;

   number_type  known_primes [PrimeSlots];
   verdict_type awaited_verdicts [$];

   // Tests one candidate against every held prime and appends it when nothing divides it and a slot is free.
   function automatic verdict_type sieve_candidate(input number_type value);
      verdict_type verdict;
      logic        divided;
      divided = 1'b0;
      for (int k = 0; k < held_primes; k++) begin
         if (known_primes[k] != '0 && (value % known_primes[k]) == '0) begin
            divided = 1'b1;
         end
      end
      verdict.candidate  = value;
      verdict.is_prime   = !divided;
      verdict.appended   = !divided && held_primes < PrimeSlots;
      verdict.table_full = !divided && held_primes >= PrimeSlots;
      if (verdict.appended) begin
         known_primes[held_primes] = value;
         held_primes++;
      end
      verdict.prime_count = CountFieldBits'(held_primes);
      return verdict;
   endfunction

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", what);
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type fresh;
      if (reset) begin
         known_primes[0] = FirstPrime;
         held_primes     = 1;
         awaited_verdicts.delete();
         error_count     = 0;
         checked_count   = 0;
         prime_results   = 0;
         full_results    = 0;
      end else begin
         // The result side is handled first so that a transfer in the same cycle as a new
         // candidate can never be matched against that candidate.
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (awaited_verdicts.size() == 0) begin
               note_failure($sformatf(
                  "Result with no candidate pending: prime %0b appended %0b full %0b count %0d.",
                  rsp_is_prime, rsp_appended, rsp_table_full, rsp_prime_count));
            end else begin
               want = awaited_verdicts.pop_front();
               if (want.is_prime) prime_results++;
               if (want.table_full) full_results++;
               if (rsp_is_prime !== want.is_prime || rsp_appended !== want.appended ||
                   rsp_table_full !== want.table_full ||
                   rsp_prime_count !== want.prime_count) begin
                  note_failure($sformatf(
                     "Candidate %0d: expected prime %0b appended %0b full %0b count %0d, %s",
                     want.candidate, want.is_prime, want.appended, want.table_full,
                     want.prime_count,
                     $sformatf("got prime %0b appended %0b full %0b count %0d.",
                        rsp_is_prime, rsp_appended, rsp_table_full, rsp_prime_count)));
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh            = sieve_candidate(req_candidate);
            awaited_verdicts = {awaited_verdicts, fresh};
         end
      end
      outstanding = awaited_verdicts.size();
   end

endmodule

/* dv/trial_division_prime_table_tb.sv */
// Testbench top of the trial division prime table: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps
module trial_division_prime_table_tb;

   localparam int ClockHalf     = 6;
   localparam int ResetCycles   = 10;
   // Random candidates sent between the directed ones and the closing one.
   localparam int RandomItems   = 561;
   // The first two pacing phases each last this many transfers on the request side.
   localparam int PhaseItems    = 193;
   // One item passes through every cell of the chain, so a quiet stretch of this length
   // can only mean that the block has hung.
   localparam int QuietLimit    = 20000;
   // After the last result, a drain period of this length lets any stray result show up.
   localparam int DrainCycles   = 2200;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [31:0] req_candidate = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_is_prime;
   logic        rsp_appended;
   logic        rsp_table_full;
   logic [10:0] rsp_prime_count;

   int error_count;
   int outstanding;
   int held_primes;
   int checked_count;
   int prime_results;
   int full_results;

   int items_sent     = 0;
   int send_idle_pct  = 33;
   int recv_stall_pct = 57;
   int quiet_cycles   = 0;

   // The directed candidates walk through the corner cases while the table is small:
   // the first odd primes, a repeat of 2 and of 3, which are divisible by themselves,
   // zero, which 2 divides, small composites, and the extremes of the 32-bit field.
   // All ones is 3 * 5 * 17 * 257 * 65537, so it is composite; the largest 32-bit prime
   // and 2^31 - 1 are appended, as is 65537. The walk of true primes resumes after 13.
   logic [31:0] directed_candidates [0:17] = '{
      32'd3, 32'd4, 32'd5, 32'd2, 32'd3, 32'd0, 32'd9, 32'd7,
      32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
      32'd49, 32'd11, 32'd121, 32'h0001_0001, 32'd13
   };

   trial_division_prime_table dut (.*);

   trial_division_prime_table_checker result_checker (.*);

   always #ClockHalf clock = ~clock;

   // The receiver decides afresh at every falling edge whether to hold off the result.
   always @(negedge clock) rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);

   // Any transfer on either channel proves progress; a long silence ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("No transfer for %0d cycles; %0d results still pending.",
                  QuietLimit, outstanding);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Smallest true prime above the given number, found by plain trial division.
   function automatic int unsigned prime_after(input int unsigned start);
      int unsigned probe;
      bit          composite;
      probe = start;
      do begin
         probe++;
         composite = 1'b0;
         for (int unsigned d = 2; d * d <= probe; d++) begin
            if (probe % d == 0) composite = 1'b1;
         end
      end while (composite);
      return probe;
   endfunction

   // Presents one candidate at the falling edge and holds it until the block takes it.
   // The pacing of both sides is set here from the number of transfers so far: first the
   // sender idles often and the receiver stalls more, then the other way round, and in the
   // last phase neither side holds back.
   task automatic send_candidate(input logic [31:0] value);
      if (items_sent < PhaseItems) begin
         send_idle_pct  = 33;
         recv_stall_pct = 57;
      end else if (items_sent < 2 * PhaseItems) begin
         send_idle_pct  = 57;
         recv_stall_pct = 33;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_candidate = value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   initial begin
      int unsigned walk;
      int unsigned value;
      int          pick;
      int          random_sent;
      walk        = 13;
      random_sent = 0;
      repeat (ResetCycles) @(negedge clock);
      reset = 1'b0;

      foreach (directed_candidates[i]) begin
         send_candidate(directed_candidates[i]);
      end

      // The random part mostly feeds the next true prime, as the program does, so that the
      // table keeps growing. The rest are products that some held prime must divide,
      // repeats of small values and arbitrary 32-bit noise. One is kept out here: once
      // stored it would divide every later candidate.
      while (random_sent < RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 93) begin
            walk  = prime_after(walk);
            value = walk;
         end else if (pick < 96) begin
            value = $urandom_range(3, walk) * $urandom_range(2, 50);
         end else if (pick < 98) begin
            value = $urandom_range(2, walk);
         end else begin
            value = $urandom;
            if (value == 1) value = 0;
         end
         send_candidate(value);
         random_sent++;
      end

      // One comes last: no held prime divides it, so it is reported prime and appended.
      send_candidate(32'd1);
      req_valid = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("Sent %0d candidates (%0d directed, %0d random, then one); %0d results checked.",
               items_sent, $size(directed_candidates), random_sent, checked_count);
      $display("%0d were prime, %0d found the table full; %0d primes held; %0d mismatches.",
               prime_results, full_results, held_primes, error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
